// File: rtl/core/wsl_pkg.sv
// Shared types and constants for the wavio sequence length block.
package wsl_pkg;
	localparam int VALUE_WIDTH   = 32;
	localparam int MAX_LEN_DEF   = 1024;
	localparam int RESULT_WIDTH  = 11;

	localparam logic [1:0] TK_NONE = 2'd0;
	localparam logic [1:0] TK_FWD  = 2'd1;
	localparam logic [1:0] TK_BWD  = 2'd2;
	localparam logic [1:0] TK_CLR  = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic       found;
	} tok_ctrl_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic                          last;
	} in_item_t;

	typedef struct packed {
		logic [RESULT_WIDTH-1:0] wavio_length;
		logic                    overflow;
	} out_item_t;
endpackage

// File: rtl/core/wsl_stream_if.sv
// Valid/ready stream interface that carries one item per handshake.
interface wsl_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/wsl_ram.sv
// Generic single write port RAM with a registered read port.
module wsl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/core/wsl_cell.sv
// One cell of the tails chain: holds one tail and passes each key on.
module wsl_cell #(
	parameter int INDEX = 0,
	parameter int MAX_LEN = wsl_pkg::MAX_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wsl_pkg::tok_ctrl_t                  up_ctrl,
	input  logic [wsl_pkg::VALUE_WIDTH-1:0]     up_key,
	input  logic [$clog2(MAX_LEN+1)-1:0]        up_len,
	input  logic [$clog2(MAX_LEN)-1:0]          up_idx,
	input  logic [$clog2(MAX_LEN+1)-1:0]        up_fwd,
	output wsl_pkg::tok_ctrl_t                  dn_ctrl,
	output logic [wsl_pkg::VALUE_WIDTH-1:0]     dn_key,
	output logic [$clog2(MAX_LEN+1)-1:0]        dn_len,
	output logic [$clog2(MAX_LEN)-1:0]          dn_idx,
	output logic [$clog2(MAX_LEN+1)-1:0]        dn_fwd
);
	import wsl_pkg::*;

	localparam int LW = $clog2(MAX_LEN+1);

	logic                   tail_valid_q;
	logic [VALUE_WIDTH-1:0] tail_q;
	logic                   hit;

	assign hit = (up_ctrl.kind == TK_FWD || up_ctrl.kind == TK_BWD) && !up_ctrl.found
		&& (!tail_valid_q || tail_q >= up_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_valid_q <= 1'b0;
			dn_ctrl      <= '{kind: TK_NONE, found: 1'b0};
		end else begin
			if (up_ctrl.kind == TK_CLR) begin
				tail_valid_q <= 1'b0;
			end else if (hit) begin
				tail_valid_q <= 1'b1;
			end
			dn_ctrl.kind  <= up_ctrl.kind;
			dn_ctrl.found <= up_ctrl.found | hit;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			tail_q <= up_key;
		end
		dn_key <= up_key;
		dn_len <= hit ? LW'(INDEX + 1) : up_len;
		dn_idx <= up_idx;
		dn_fwd <= up_fwd;
	end
endmodule

// File: rtl/core/wavio_sequence_length.sv
// Wavio sequence length: top level with the sequencer, stores and tails chain.
// Forward items are taken one per cycle while the sequencer is in its run state;
// each key walks a chain of MAX_LEN cells, one cell per cycle, and its run length
// is stored when it leaves the last cell. The item marked last is followed by a
// wait for the chain to drain, a state that clears the chain, N reads of the
// stored values (N = stored elements) fed backwards into the same chain, another
// drain wait and a state that loads the result and clears the chain again; that
// state waits while the sink still holds an earlier result.
module wavio_sequence_length #(
	parameter int MAX_LEN = wsl_pkg::MAX_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	wsl_stream_if.sink   samples,
	wsl_stream_if.source results
);
	import wsl_pkg::*;

	localparam int LW = $clog2(MAX_LEN+1);
	localparam int IW = $clog2(MAX_LEN);
	localparam int DRAIN_CYC = MAX_LEN + 4;
	localparam int TW = $clog2(DRAIN_CYC+1);

	localparam logic [2:0] ST_RUN    = 3'd0;
	localparam logic [2:0] ST_FDRAIN = 3'd1;
	localparam logic [2:0] ST_CLR    = 3'd2;
	localparam logic [2:0] ST_BRD    = 3'd3;
	localparam logic [2:0] ST_BDRAIN = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]    state_q;
	logic [LW-1:0] count_q;
	logic [IW-1:0] rd_ptr_q;
	logic [TW-1:0] timer_q;
	logic          dropped_q;
	logic [LW-1:0] best_q;
	logic          rd_s1;
	logic          accept;

	tok_ctrl_t              c_ctrl [MAX_LEN+1];
	logic [VALUE_WIDTH-1:0] c_key  [MAX_LEN+1];
	logic [LW-1:0]          c_len  [MAX_LEN+1];
	logic [IW-1:0]          c_idx  [MAX_LEN+1];
	logic [LW-1:0]          c_fwd  [MAX_LEN+1];

	logic [VALUE_WIDTH-1:0] key_in;
	logic                   vs_we;
	logic [VALUE_WIDTH-1:0] vs_rdata;
	logic                   fl_we;
	logic [LW-1:0]          fl_rdata;
	tok_ctrl_t              end_ctrl;
	logic [LW-1:0]          end_min;

	assign samples.ready = (state_q == ST_RUN);
	assign accept = samples.valid && samples.ready;
	assign key_in = samples.payload.value ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	assign vs_we = accept && (count_q < LW'(MAX_LEN));

	wsl_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_LEN)) u_values (
		.clk   (clk),
		.we    (vs_we),
		.waddr (count_q[IW-1:0]),
		.wdata (key_in),
		.raddr (rd_ptr_q),
		.rdata (vs_rdata)
	);

	assign end_ctrl = c_ctrl[MAX_LEN];
	assign fl_we = (end_ctrl.kind == TK_FWD);
	assign end_min = (c_fwd[MAX_LEN] < c_len[MAX_LEN]) ? c_fwd[MAX_LEN] : c_len[MAX_LEN];

	wsl_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_fwd_len (
		.clk   (clk),
		.we    (fl_we),
		.waddr (c_idx[MAX_LEN]),
		.wdata (c_len[MAX_LEN]),
		.raddr (rd_ptr_q),
		.rdata (fl_rdata)
	);

	genvar g;
	generate
		for (g = 0; g < MAX_LEN; g++) begin : g_cell
			wsl_cell #(.INDEX(g), .MAX_LEN(MAX_LEN)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.up_ctrl (c_ctrl[g]),
				.up_key  (c_key[g]),
				.up_len  (c_len[g]),
				.up_idx  (c_idx[g]),
				.up_fwd  (c_fwd[g]),
				.dn_ctrl (c_ctrl[g+1]),
				.dn_key  (c_key[g+1]),
				.dn_len  (c_len[g+1]),
				.dn_idx  (c_idx[g+1]),
				.dn_fwd  (c_fwd[g+1])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		c_key[0] <= rd_s1 ? vs_rdata : key_in;
		c_len[0] <= '0;
		c_idx[0] <= count_q[IW-1:0];
		c_fwd[0] <= fl_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_RUN;
			count_q         <= '0;
			rd_ptr_q        <= '0;
			timer_q         <= '0;
			dropped_q       <= 1'b0;
			best_q          <= '0;
			rd_s1           <= 1'b0;
			c_ctrl[0]       <= '{kind: TK_NONE, found: 1'b0};
			results.valid   <= 1'b0;
			results.payload <= '0;
		end else begin
			c_ctrl[0] <= '{kind: TK_NONE, found: 1'b0};
			rd_s1     <= 1'b0;
			if (rd_s1) begin
				c_ctrl[0] <= '{kind: TK_BWD, found: 1'b0};
			end
			if (end_ctrl.kind == TK_BWD && end_min > best_q) begin
				best_q <= end_min;
			end
			if (results.valid && results.ready) begin
				results.valid <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (accept) begin
						if (vs_we) begin
							c_ctrl[0] <= '{kind: TK_FWD, found: 1'b0};
							count_q   <= count_q + LW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (samples.payload.last) begin
							timer_q <= '0;
							state_q <= ST_FDRAIN;
						end
					end
				end
				ST_FDRAIN: begin
					timer_q <= timer_q + TW'(1);
					if (timer_q == TW'(DRAIN_CYC)) begin
						state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					c_ctrl[0] <= '{kind: TK_CLR, found: 1'b0};
					best_q    <= '0;
					rd_ptr_q  <= IW'(count_q - LW'(1));
					state_q   <= ST_BRD;
				end
				ST_BRD: begin
					rd_s1 <= 1'b1;
					if (rd_ptr_q == '0) begin
						timer_q <= '0;
						state_q <= ST_BDRAIN;
					end else begin
						rd_ptr_q <= rd_ptr_q - IW'(1);
					end
				end
				ST_BDRAIN: begin
					timer_q <= timer_q + TW'(1);
					if (timer_q == TW'(DRAIN_CYC)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!results.valid || results.ready) begin
						c_ctrl[0]                    <= '{kind: TK_CLR, found: 1'b0};
						results.valid                <= 1'b1;
						results.payload.wavio_length <=
							RESULT_WIDTH'({best_q, 1'b0} - {{LW{1'b0}}, 1'b1});
						results.payload.overflow     <= dropped_q;
						count_q                      <= '0;
						dropped_q                    <= 1'b0;
						state_q                      <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end
endmodule

// File: tb/wsl_checker.sv
// Checker for the wavio sequence length block: predicts each result and compares it.
module wsl_checker #(
	parameter int MAX_LEN = wsl_pkg::MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  wsl_pkg::in_item_t in_item,
	input  logic              out_valid,
	input  logic              out_ready,
	input  wsl_pkg::out_item_t out_item,
	output int                failures,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import wsl_pkg::*;

	logic signed [VALUE_WIDTH-1:0] stored_values [MAX_LEN];
	int                            rise_lengths [MAX_LEN];
	logic signed [VALUE_WIDTH-1:0] tails [MAX_LEN];
	int                            tail_count;
	int                            stored_count;
	logic                          dropped;
	out_item_t                     wavio_expected [$];
	int                            mismatches;

	function automatic int place_tail(input logic signed [VALUE_WIDTH-1:0] key);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = tail_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tails[mid] < key) lo = mid + 1;
			else hi = mid;
		end
		if (lo < MAX_LEN) begin
			tails[lo] = key;
			if (lo == tail_count) tail_count++;
		end
		return lo + 1;
	endfunction

	task automatic take_sample(input in_item_t item);
		int        best;
		int        fall;
		int        shorter;
		out_item_t res;
		if (stored_count < MAX_LEN) begin
			stored_values[stored_count] = item.value;
			rise_lengths[stored_count] = place_tail(item.value);
			stored_count++;
		end else begin
			dropped = 1'b1;
		end
		if (item.last) begin
			tail_count = 0;
			best = 0;
			for (int i = stored_count - 1; i >= 0; i--) begin
				fall = place_tail(stored_values[i]);
				shorter = rise_lengths[i] < fall ? rise_lengths[i] : fall;
				if (shorter > best) best = shorter;
			end
			res.wavio_length = RESULT_WIDTH'(2 * best - 1);
			res.overflow = dropped;
			wavio_expected.push_back(res);
			stored_count = 0;
			tail_count = 0;
			dropped = 1'b0;
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (wavio_expected.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: wavio_length=%0d overflow=%0b",
					got.wavio_length, got.overflow);
		end else begin
			want = wavio_expected.pop_front();
			if (got.wavio_length !== want.wavio_length || got.overflow !== want.overflow) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: wavio_length exp %0d got %0d, overflow exp %0b got %0b",
						want.wavio_length, got.wavio_length, want.overflow, got.overflow);
			end
		end
	endtask

	initial begin
		tail_count = 0;
		stored_count = 0;
		dropped = 1'b0;
		mismatches = 0;
		failures = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) take_sample(in_item);
			if (out_valid && out_ready) check_result(out_item);
		end
		pending <= wavio_expected.size();
		failures <= mismatches + wavio_expected.size();
	end
endmodule

// File: tb/tb_top.sv
// Testbench top for the wavio sequence length block: clock, reset, stimulus and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wsl_pkg::*;

	localparam int MAX_LEN = MAX_LEN_DEF;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 2 * MAX_LEN + 100;

	logic clk;
	logic arst_n;
	int   cycles;
	int   items_sent;
	int   sequences_sent;
	bit   source_calm;
	int   failures;
	int   pending;

	wsl_stream_if #(.payload_t(in_item_t))  samples_if ();
	wsl_stream_if #(.payload_t(out_item_t)) results_if ();

	wavio_sequence_length #(.MAX_LEN(MAX_LEN)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if.sink),
		.results(results_if.source)
	);

	wsl_checker #(.MAX_LEN(MAX_LEN)) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(samples_if.valid),
		.in_ready(samples_if.ready),
		.in_item(samples_if.payload),
		.out_valid(results_if.valid),
		.out_ready(results_if.ready),
		.out_item(results_if.payload),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		samples_if.valid = 1'b0;
		samples_if.payload = '0;
		results_if.ready = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (cycles >= 60000 && cycles < 100000) results_if.ready <= 1'b1;
		else results_if.ready <= $urandom_range(99) >= 34;
	end

	task automatic send_sample(input logic signed [VALUE_WIDTH-1:0] v, input logic is_last);
		in_item_t item;
		item.value = v;
		item.last = is_last;
		if (!source_calm && $urandom_range(99) < 34) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 34) @(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.payload <= item;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		items_sent++;
		if (is_last) sequences_sent++;
	endtask

	function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $urandom;
			default: return $signed($urandom_range(20)) - 10;
		endcase
	endfunction

	task automatic send_sequence(input int len);
		for (int i = 0; i < len; i++) send_sample(pick_value(), i == len - 1);
	endtask

	initial begin
		int long_at;
		int seq_no;
		items_sent = 0;
		sequences_sent = 0;
		source_calm = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single element, extremes, a short rise and fall, equal values, a pure fall and a full rise then fall.
		send_sample(5, 1'b1);
		send_sample(32'sh80000000, 1'b0);
		send_sample(32'sh7fffffff, 1'b1);
		send_sample(1, 1'b0);
		send_sample(3, 1'b0);
		send_sample(2, 1'b1);
		send_sample(4, 1'b0);
		send_sample(4, 1'b0);
		send_sample(4, 1'b1);
		send_sample(32'sh7fffffff, 1'b0);
		send_sample(0, 1'b0);
		send_sample(32'sh80000000, 1'b1);
		for (int i = 1; i <= 5; i++) send_sample(i, 1'b0);
		for (int i = 4; i >= 1; i--) send_sample(i, i == 1);

		// Short random sequences with one sequence past the storage limit whose
		// closing item is itself dropped.
		long_at = $urandom_range(10, 40);
		seq_no = 0;
		while (items_sent < 1420) begin
			source_calm = seq_no >= 45 && seq_no < 60;
			if (seq_no == long_at) send_sequence(MAX_LEN + 1);
			else send_sequence($urandom_range(1, 12));
			seq_no++;
		end
		samples_if.valid <= 1'b0;

		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items in %0d sequences, one of them past the %0d-entry store.",
			items_sent, sequences_sent, MAX_LEN);
		$display("Covered value extremes, equal runs and random stalls on both sides.");
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// File: sim.f
rtl/core/wsl_pkg.sv
rtl/core/wsl_stream_if.sv
rtl/core/wsl_ram.sv
rtl/core/wsl_cell.sv
rtl/core/wavio_sequence_length.sv
tb/wsl_checker.sv
tb/tb_top.sv
